/* rtl/core/pidc_pkg.sv */
// shared widths, register codes, reset values and the configuration struct of the pid step
package pidc_pkg;

    localparam int ERROR_WIDTH     = 24;
    localparam int GAIN_WIDTH      = 8;
    localparam int LIMIT_WIDTH     = 31;
    localparam int SUM_WIDTH       = 32;
    localparam int DRIVE_WIDTH     = 48;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = LIMIT_WIDTH;

    localparam int DIFF_WIDTH  = ERROR_WIDTH + 1;
    localparam int PROD_P_WIDTH = GAIN_WIDTH + 1 + ERROR_WIDTH;
    localparam int PROD_I_WIDTH = GAIN_WIDTH + 1 + SUM_WIDTH;
    localparam int PROD_D_WIDTH = GAIN_WIDTH + 1 + DIFF_WIDTH;

    localparam logic [GAIN_WIDTH-1:0]  GAIN_P_RESET = GAIN_WIDTH'(25);
    localparam logic [GAIN_WIDTH-1:0]  GAIN_I_RESET = GAIN_WIDTH'(10);
    localparam logic [GAIN_WIDTH-1:0]  GAIN_D_RESET = GAIN_WIDTH'(80);
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET  = LIMIT_WIDTH'(9500000);

    localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_GAIN_P         = 2'd0,
        REG_GAIN_I         = 2'd1,
        REG_GAIN_D         = 2'd2,
        REG_INTEGRAL_LIMIT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [GAIN_WIDTH-1:0]  gain_p;
        logic [GAIN_WIDTH-1:0]  gain_i;
        logic [GAIN_WIDTH-1:0]  gain_d;
        logic [LIMIT_WIDTH-1:0] integral_limit;
    } cfg_t;

endpackage

/* rtl/core/pidc_cfg.sv */
// configuration register file: three gains and the integral limit
module pidc_cfg
    import pidc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                REG_GAIN_P:         cfg_next.gain_p = cfg_data[GAIN_WIDTH-1:0];
                REG_GAIN_I:         cfg_next.gain_i = cfg_data[GAIN_WIDTH-1:0];
                REG_GAIN_D:         cfg_next.gain_d = cfg_data[GAIN_WIDTH-1:0];
                REG_INTEGRAL_LIMIT: cfg_next.integral_limit = cfg_data[LIMIT_WIDTH-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p         <= GAIN_P_RESET;
            cfg_reg.gain_i         <= GAIN_I_RESET;
            cfg_reg.gain_d         <= GAIN_D_RESET;
            cfg_reg.integral_limit <= LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/core/pidc_acc.sv */
// integrator state: clamped running error sum and previous error, updated per request
module pidc_acc
    import pidc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic signed [ERROR_WIDTH-1:0] error_sample,
    input  logic                          start_req,
    input  logic [LIMIT_WIDTH-1:0]        limit,
    output logic signed [SUM_WIDTH-1:0]   sum_new,
    output logic signed [DIFF_WIDTH-1:0]  diff_new
);

    logic signed [SUM_WIDTH-1:0]   sum_reg;
    logic signed [SUM_WIDTH-1:0]   sum_next;
    logic signed [ERROR_WIDTH-1:0] prev_reg;
    logic signed [ERROR_WIDTH-1:0] prev_next;
    logic signed [SUM_WIDTH-1:0]   sum_base;
    logic signed [ERROR_WIDTH-1:0] prev_base;
    logic signed [SUM_WIDTH:0]     sum_wide;
    logic signed [SUM_WIDTH:0]     limit_wide;

    // start clears the history before this step
    assign sum_base  = start_req ? '0 : sum_reg;
    assign prev_base = start_req ? '0 : prev_reg;

    assign sum_wide   = {sum_base[SUM_WIDTH-1], sum_base}
                      + {{(SUM_WIDTH+1-ERROR_WIDTH){error_sample[ERROR_WIDTH-1]}}, error_sample};
    assign limit_wide = {{(SUM_WIDTH+1-LIMIT_WIDTH){1'b0}}, limit};

    always_comb
    begin
        if (sum_wide > limit_wide)
            sum_new = $signed({1'b0, limit});
        else if (sum_wide[SUM_WIDTH] && !sum_wide[SUM_WIDTH-1])
            sum_new = $signed(SUM_MIN);   // negative overflow saturates
        else
            sum_new = sum_wide[SUM_WIDTH-1:0];
    end

    assign diff_new = {error_sample[ERROR_WIDTH-1], error_sample}
                    - {prev_base[ERROR_WIDTH-1], prev_base};

    assign sum_next  = accept ? sum_new : sum_reg;
    assign prev_next = accept ? error_sample : prev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            prev_reg <= '0;
        end
        else
        begin
            sum_reg  <= sum_next;
            prev_reg <= prev_next;
        end
    end

    a_prev_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> prev_reg == $past(error_sample))
        else $error("previous error not taken from last request");

    a_sum_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> sum_reg <= $signed({1'b0, $past(limit)}))
        else $error("error sum above integral limit");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(sum_reg) && $stable(prev_reg))
        else $error("integrator state moved without a request");

endmodule

/* rtl/core/pid_step_with_integral_clamp.sv */
// top level of the pid step: request/result pipeline, products and drive sum
//
//  channel   direction  handshake                 payload
//  sample    in         sample_valid/sample_stall error_sample, start_req
//  result    out        drive_valid/drive_stall   drive
//  cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// one request per cycle unless stalled; drive_valid rises as stage c loads it
// the integrator (add and clamp) is the loop through sum_reg that sets the rate
// reset restores the default gains and limit and clears sum and previous error
// sample_stall rises only when all three stages hold data and drive_stall is high
module pid_step_with_integral_clamp
    import pidc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic signed [ERROR_WIDTH-1:0] error_sample,
    input  logic                          start_req,
    output logic                          drive_valid,
    input  logic                          drive_stall,
    output logic signed [DRIVE_WIDTH-1:0] drive,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]     cfg_data
);

    cfg_t cfg;

    logic accept;
    logic a_load, b_load, c_load;
    logic a_open, b_open, c_open;

    logic a_valid_reg, b_valid_reg, c_valid_reg;

    logic signed [SUM_WIDTH-1:0]   sum_new;
    logic signed [DIFF_WIDTH-1:0]  diff_new;

    logic signed [ERROR_WIDTH-1:0] e_reg;
    logic signed [SUM_WIDTH-1:0]   s_reg;
    logic signed [DIFF_WIDTH-1:0]  diff_reg;

    logic signed [PROD_P_WIDTH-1:0] prod_p_reg, prod_p_next;
    logic signed [PROD_I_WIDTH-1:0] prod_i_reg, prod_i_next;
    logic signed [PROD_D_WIDTH-1:0] prod_d_reg, prod_d_next;

    logic [DRIVE_WIDTH-1:0] drive_reg, drive_next;

    pidc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pidc_acc u_acc (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .error_sample (error_sample),
        .start_req    (start_req),
        .limit        (cfg.integral_limit),
        .sum_new      (sum_new),
        .diff_new     (diff_new)
    );

    // a stage can take data when empty or when its content moves on
    assign c_open = !c_valid_reg || !drive_stall;
    assign b_open = !b_valid_reg || c_open;
    assign a_open = !a_valid_reg || b_open;

    assign sample_stall = !a_open;
    assign accept       = sample_valid && a_open;
    assign a_load       = accept;
    assign b_load       = a_valid_reg && b_open;
    assign c_load       = b_valid_reg && c_open;

    assign prod_p_next = $signed({1'b0, cfg.gain_p}) * e_reg;
    assign prod_i_next = $signed({1'b0, cfg.gain_i}) * s_reg;
    assign prod_d_next = $signed({1'b0, cfg.gain_d}) * diff_reg;

    assign drive_next = {{(DRIVE_WIDTH-PROD_P_WIDTH){prod_p_reg[PROD_P_WIDTH-1]}}, prod_p_reg}
                      + {{(DRIVE_WIDTH-PROD_I_WIDTH){prod_i_reg[PROD_I_WIDTH-1]}}, prod_i_reg}
                      + {{(DRIVE_WIDTH-PROD_D_WIDTH){prod_d_reg[PROD_D_WIDTH-1]}}, prod_d_reg};

    assign drive_valid = c_valid_reg;
    assign drive       = $signed(drive_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_open)
                a_valid_reg <= sample_valid;
            if (b_open)
                b_valid_reg <= a_valid_reg;
            if (c_open)
                c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            e_reg    <= error_sample;
            s_reg    <= sum_new;
            diff_reg <= diff_new;
        end
        if (b_load)
        begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            prod_d_reg <= prod_d_next;
        end
        if (c_load)
            drive_reg <= drive_next;
    end

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> a_valid_reg && b_valid_reg && c_valid_reg && drive_stall)
        else $error("request stalled with room in the pipeline");

    a_stage_b_fill: assert property (@(posedge clk) disable iff (!rst_n)
        b_load |=> b_valid_reg)
        else $error("product stage lost a request");

    a_stage_c_fill: assert property (@(posedge clk) disable iff (!rst_n)
        c_load |=> c_valid_reg)
        else $error("result stage lost a request");

endmodule

/* tb/sv/pid_step_with_integral_clamp_tb.sv */
// self-checking testbench for the pid step with integral clamp
`timescale 1ns / 100ps

module pid_step_with_integral_clamp_tb
    import pidc_pkg::*;
();

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 60;
    localparam int SETTLE_CYCLES = 6;

    localparam logic signed [ERROR_WIDTH-1:0] ERR_MAX = {1'b0, {(ERROR_WIDTH-1){1'b1}}};
    localparam logic signed [ERROR_WIDTH-1:0] ERR_MIN = {1'b1, {(ERROR_WIDTH-1){1'b0}}};
    localparam logic [CFG_DATA_WIDTH-1:0]     LIMIT_MAX = '1;
    localparam longint                        SUM_FLOOR = -64'sd2147483648;

    typedef struct {
        logic signed [ERROR_WIDTH-1:0] err;
        logic                          restart;
    } sample_req_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          sample_valid = 1'b0;
    logic                          sample_stall;
    logic signed [ERROR_WIDTH-1:0] error_sample = '0;
    logic                          start_req = 1'b0;
    logic                          drive_valid;
    logic                          drive_stall = 1'b0;
    logic signed [DRIVE_WIDTH-1:0] drive;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]    cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]     cfg_data = '0;

    // controller copy: settings and integrator state
    logic [GAIN_WIDTH-1:0]         kp = 8'd25;
    logic [GAIN_WIDTH-1:0]         ki = 8'd10;
    logic [GAIN_WIDTH-1:0]         kd = 8'd80;
    logic [LIMIT_WIDTH-1:0]        sum_limit = 31'd9500000;
    logic signed [SUM_WIDTH-1:0]   run_sum = '0;
    logic signed [ERROR_WIDTH-1:0] prev_err = '0;

    sample_req_t                   pending_samples[$];
    sample_req_t                   next_req;
    logic signed [DRIVE_WIDTH-1:0] expected_drives[$];
    logic signed [DRIVE_WIDTH-1:0] want_drive;

    int  samples_queued = 0;
    int  results_seen = 0;
    int  error_count = 0;
    int  reg_writes = 0;
    int  clamp_hits = 0;
    int  floor_hits = 0;
    int  cycle_count = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    int  hold_requests = 0;
    int  hold_seen = 0;
    bit  sender_gaps = 1'b1;
    bit  receiver_stalls = 1'b1;

    pid_step_with_integral_clamp dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .error_sample (error_sample),
        .start_req    (start_req),
        .drive_valid  (drive_valid),
        .drive_stall  (drive_stall),
        .drive        (drive),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // one controller step: returns the drive and advances sum and previous error
    function automatic logic signed [DRIVE_WIDTH-1:0] pid_drive(
        input logic signed [ERROR_WIDTH-1:0] err,
        input logic                          restart
    );
        longint e;
        longint s;
        longint d;
        e = err;
        if (restart)
        begin
            run_sum  = '0;
            prev_err = '0;
        end
        s = longint'(run_sum) + e;
        if (s > longint'(sum_limit))
        begin
            s = longint'(sum_limit);
            clamp_hits++;
        end
        // no lower bound register: saturate instead of wrapping
        if (s < SUM_FLOOR)
        begin
            s = SUM_FLOOR;
            floor_hits++;
        end
        d = longint'(kp) * e + longint'(ki) * s + longint'(kd) * (e - longint'(prev_err));
        run_sum  = s[SUM_WIDTH-1:0];
        prev_err = err;
        return d[DRIVE_WIDTH-1:0];
    endfunction

    // mostly zero, sometimes short, rarely long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [ERROR_WIDTH-1:0] random_error();
        case ($urandom_range(0, 9))
            0:       return ERR_MAX;
            1:       return ERR_MIN;
            2:       return '0;
            3:       return ERROR_WIDTH'($urandom_range(0, 64) - 32);
            default: return ERROR_WIDTH'($urandom());
        endcase
    endfunction

    // upper data bits are random so the gain registers must ignore them
    function automatic logic [CFG_DATA_WIDTH-1:0] random_gain();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return CFG_DATA_WIDTH'(8'hFF);
            default: return CFG_DATA_WIDTH'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_DATA_WIDTH-1:0] random_limit();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return LIMIT_MAX;
            2, 3:    return CFG_DATA_WIDTH'($urandom_range(0, 100));
            4, 5:    return CFG_DATA_WIDTH'($urandom_range(0, 32'h0100_0000));
            default: return CFG_DATA_WIDTH'($urandom());
        endcase
    endfunction

    task automatic add_sample(input logic signed [ERROR_WIDTH-1:0] err, input logic restart);
        sample_req_t req;
        req.err     = err;
        req.restart = restart;
        pending_samples.push_back(req);
        samples_queued++;
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_WIDTH-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_GAIN_P:         kp        = value[GAIN_WIDTH-1:0];
            REG_GAIN_I:         ki        = value[GAIN_WIDTH-1:0];
            REG_GAIN_D:         kd        = value[GAIN_WIDTH-1:0];
            REG_INTEGRAL_LIMIT: sum_limit = value[LIMIT_WIDTH-1:0];
            default:            ;
        endcase
        reg_writes++;
    endtask

    task automatic write_all(
        input logic [CFG_DATA_WIDTH-1:0] p,
        input logic [CFG_DATA_WIDTH-1:0] i,
        input logic [CFG_DATA_WIDTH-1:0] d,
        input logic [CFG_DATA_WIDTH-1:0] lim
    );
        write_register(REG_GAIN_P, p);
        write_register(REG_GAIN_I, i);
        write_register(REG_GAIN_D, d);
        write_register(REG_INTEGRAL_LIMIT, lim);
    endtask

    // every queued request has produced its drive, then a short pause
    task automatic wait_idle();
        @(posedge clk);
        while (results_seen < samples_queued)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            error_sample <= '0;
            start_req    <= 1'b0;
            gap_left     = 0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
                expected_drives.push_back(pid_drive(error_sample, start_req));
            if (!sample_valid || !sample_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    sample_valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    next_req = pending_samples.pop_front();
                    sample_valid <= 1'b1;
                    error_sample <= next_req.err;
                    start_req    <= next_req.restart;
                    gap_left     = sender_gaps ? idle_length() : 0;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_stall <= 1'b0;
        end
        else
        begin
            if (drive_valid && !drive_stall)
            begin
                results_seen++;
                if (expected_drives.size() == 0)
                begin
                    $error("drive result with no request outstanding: actual %0d", drive);
                    error_count++;
                end
                else
                begin
                    want_drive = expected_drives.pop_front();
                    if (drive !== want_drive)
                    begin
                        $error("drive mismatch: expected %0d, actual %0d", want_drive, drive);
                        error_count++;
                    end
                end
            end
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                drive_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                drive_stall <= 1'b1;
            end
            else
            begin
                stall_left = receiver_stalls ? idle_length() : 0;
                if (stall_left > 0)
                    stall_left--;
                drive_stall <= receiver_stalls && (stall_left > 0 || $urandom_range(0, 99) < 20);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("pid_step_with_integral_clamp_tb: errors");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: extremes, restarts, clamp at the default limit
        add_sample('0, 1'b0);
        add_sample(ERR_MAX, 1'b0);
        add_sample(ERR_MAX, 1'b0);
        add_sample(ERR_MAX, 1'b0);
        add_sample(ERR_MIN, 1'b1);
        add_sample(ERR_MIN, 1'b0);
        add_sample(-24'sd1, 1'b1);
        add_sample(24'sd1, 1'b0);
        add_sample(24'sh555555, 1'b0);
        add_sample(24'shAAAAAA, 1'b0);
        wait_idle();

        write_all('0, '0, '0, '0);
        add_sample(ERR_MAX, 1'b0);
        add_sample(ERR_MIN, 1'b0);
        add_sample(24'sd5, 1'b1);
        wait_idle();

        // limit of zero with full gains: positive sums pinned at zero
        write_all(CFG_DATA_WIDTH'(8'hFF), CFG_DATA_WIDTH'(8'hFF), CFG_DATA_WIDTH'(8'hFF), '0);
        add_sample(ERR_MAX, 1'b1);
        add_sample(ERR_MAX, 1'b0);
        add_sample(ERR_MIN, 1'b0);
        add_sample(ERR_MAX, 1'b0);
        add_sample('0, 1'b0);
        wait_idle();

        // long negative run until the sum sits at its floor
        write_all(CFG_DATA_WIDTH'(8'hFF), CFG_DATA_WIDTH'(8'hFF), CFG_DATA_WIDTH'(8'hFF),
                  LIMIT_MAX);
        add_sample(ERR_MIN, 1'b1);
        for (int n = 0; n < 320; n++)
            add_sample(($urandom_range(0, 99) < 95) ? ERR_MIN : random_error(), 1'b0);
        wait_idle();

        // receiver holds off while the sender keeps offering requests
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        write_all(random_gain(), random_gain(), random_gain(), random_limit());
        hold_requests++;
        for (int n = 0; n < 40; n++)
            add_sample(random_error(), $urandom_range(0, 99) < 8);
        wait_idle();

        for (int phase = 0; phase < 6; phase++)
        begin
            sender_gaps     = (phase != 2);
            receiver_stalls = (phase != 3);
            write_all(random_gain(), random_gain(), random_gain(), random_limit());
            for (int n = 0; n < 40; n++)
                add_sample(random_error(), $urandom_range(0, 99) < 8);
            wait_idle();
        end

        $display("summary: %0d requests over %0d register writes, %0d drive results checked",
                 samples_queued, reg_writes, results_seen);
        $display("summary: integral limit clamped on %0d steps, sum floor held on %0d steps",
                 clamp_hits, floor_hits);
        if (error_count == 0)
            $display("pid_step_with_integral_clamp_tb: clean");
        else
            $display("pid_step_with_integral_clamp_tb: errors");
        $finish;
    end

endmodule
